// ===== design/northwest_corner_transport_allocator_assert.svh =====
// Assertion macros shared by the allocator modules.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef NORTHWEST_CORNER_TRANSPORT_ALLOCATOR_ASSERT_SVH
`define NORTHWEST_CORNER_TRANSPORT_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NWCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nwca: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NWCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nwca: next-cycle check failed");

`endif

// ===== design/nwca_pkg.sv =====
package nwca_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int MAX_DESTS   = 16;
  localparam int MAX_STEPS   = MAX_SOURCES + MAX_DESTS;
  localparam int SUM_LEN     = (MAX_SOURCES > MAX_DESTS) ? MAX_SOURCES : MAX_DESTS;

  localparam int ROW_W   = 4;
  localparam int COL_W   = 4;
  localparam int CNT_W   = 5;
  localparam int VAL_W   = 16;
  localparam int AMT_W   = 20;
  localparam int SUM_W   = 24;
  localparam int COST_W  = 41;
  localparam int PROD_W  = AMT_W + VAL_W;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int SIDX_W  = $clog2(SUM_LEN);
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] ACT_SUPPLY = 2'd0;
  localparam logic [1:0] ACT_DEMAND = 2'd1;
  localparam logic [1:0] ACT_COST   = 2'd2;
  localparam logic [1:0] ACT_RUN    = 2'd3;

  localparam logic [KIND_W-1:0] BAL_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] BAL_DUMMY_SRC = 2'd1;
  localparam logic [KIND_W-1:0] BAL_DUMMY_DST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SOURCES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DESTS   = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic [VAL_W-1:0] load_value;
  } nwca_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  alloc_row;
    logic [CNT_W-1:0]  alloc_col;
    logic [AMT_W-1:0]  alloc_amount;
    logic [COST_W-1:0] running_cost;
    logic [KIND_W-1:0] balance_kind;
    logic              last_step;
  } nwca_out_t;

  typedef struct packed {
    logic load;
    logic sum_start;
    logic sum_step;
    logic balance;
    logic walk;
    logic mul;
    logic acc;
  } nwca_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic last;
  } nwca_stat_t;

endpackage

// ===== design/nwca_ctrl.sv =====
module nwca_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nwca_pkg::nwca_cmd_t  cmd,
  input  nwca_pkg::nwca_stat_t stat
);
  import nwca_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_BAL  = 7'b0000100,
    S_WALK = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_RUN) begin
            cmd.sum_start = 1'b1;
            state_next    = S_SUM;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_done) begin
          state_next = S_BAL;
        end
      end
      S_BAL: begin
        cmd.balance = 1'b1;
        state_next  = S_WALK;
      end
      S_WALK: begin
        cmd.walk   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // The word sits in the output register until the sink takes it.
        if (out_ready) begin
          state_next = stat.last ? S_IDLE : S_WALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

`include "northwest_corner_transport_allocator_assert.svh"

  `NWCA_ASSERT_SAME(a_sides_exclusive, in_ready, !out_valid)
  `NWCA_ASSERT_NEXT(a_run_starts_sum, in_valid && in_ready && in_action == ACT_RUN, state == S_SUM)
  `NWCA_ASSERT_NEXT(a_more_steps, out_valid && out_ready && !stat.last, state == S_WALK)
  `NWCA_ASSERT_NEXT(a_run_ends, out_valid && out_ready && stat.last, in_ready)

endmodule

// ===== design/nwca_dp.sv =====
module nwca_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [nwca_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [nwca_pkg::CNT_W-1:0]              cfg_data,
  input  nwca_pkg::nwca_in_t                      in_word,
  input  nwca_pkg::nwca_cmd_t                     cmd,
  output nwca_pkg::nwca_stat_t                    stat,
  output nwca_pkg::nwca_out_t                     out_word
);
  import nwca_pkg::*;

  // Configuration.
  logic [CNT_W-1:0] num_sources;
  logic [CNT_W-1:0] num_dests;

  // Stores: the dummy goes in the entry just past the active count; the extra entry of each list makes room.
  logic [AMT_W-1:0] supply [MAX_SOURCES+1];
  logic [AMT_W-1:0] demand [MAX_DESTS+1];
  logic [VAL_W-1:0] cost_mem [2**(ROW_W+COL_W)];

  logic [CNT_W-1:0]  rm;
  logic [CNT_W-1:0]  rn;
  logic [CNT_W-1:0]  m_lim;
  logic [CNT_W-1:0]  n_lim;
  logic [SIDX_W-1:0] sidx;
  logic [SUM_W-1:0]  sum_s;
  logic [SUM_W-1:0]  sum_d;
  logic [SUM_W-1:0]  remain;
  logic [KIND_W-1:0] kind;
  logic [CNT_W-1:0]  walk_row;
  logic [CNT_W-1:0]  walk_col;
  logic [CNT_W-1:0]  cur_row;
  logic [CNT_W-1:0]  cur_col;
  logic [AMT_W-1:0]  amt;
  logic              dummy;
  logic [VAL_W-1:0]  cost_rd;
  logic [PROD_W-1:0] prod;
  logic [COST_W-1:0] cost_total;
  logic [STEP_W-1:0] step_cnt;
  nwca_out_t         out_reg;

  logic [CNT_W-1:0]  ns_clamp;
  logic [CNT_W-1:0]  nd_clamp;
  logic [CNT_W-1:0]  sup_addr;
  logic [CNT_W-1:0]  dem_addr;
  logic [AMT_W-1:0]  sup_rd;
  logic [AMT_W-1:0]  dem_rd;
  logic              s_lt_d;
  logic [AMT_W-1:0]  s_minus_d;
  logic [AMT_W-1:0]  d_minus_s;
  logic [VAL_W-1:0]  uc;
  logic [COST_W-1:0] total_next;
  logic [STEP_W-1:0] step_next;
  logic              last_now;
  logic              ld_row_ok;
  logic              ld_col_ok;

  // A count of zero acts as one; a count above the table acts as the table size.
  always_comb begin
    if (num_sources == '0) begin
      ns_clamp = CNT_W'(1);
    end else if (num_sources > CNT_W'(MAX_SOURCES)) begin
      ns_clamp = CNT_W'(MAX_SOURCES);
    end else begin
      ns_clamp = num_sources;
    end
    if (num_dests == '0) begin
      nd_clamp = CNT_W'(1);
    end else if (num_dests > CNT_W'(MAX_DESTS)) begin
      nd_clamp = CNT_W'(MAX_DESTS);
    end else begin
      nd_clamp = num_dests;
    end
  end

  assign sup_addr  = cmd.sum_step ? CNT_W'(sidx) : walk_row;
  assign dem_addr  = cmd.sum_step ? CNT_W'(sidx) : walk_col;
  assign sup_rd    = supply[sup_addr];
  assign dem_rd    = demand[dem_addr];
  assign s_lt_d    = (sup_rd < dem_rd);
  assign s_minus_d = sup_rd - dem_rd;
  assign d_minus_s = dem_rd - sup_rd;
  assign uc        = dummy ? '0 : cost_rd;
  assign total_next = cost_total + COST_W'(prod);
  assign step_next  = step_cnt + STEP_W'(1);
  assign last_now   = (remain == '0) || (walk_row >= m_lim) || (walk_col >= n_lim) ||
                      (step_next == STEP_W'(MAX_STEPS));
  assign ld_row_ok  = (32'(in_word.row_index) < MAX_SOURCES);
  assign ld_col_ok  = (32'(in_word.col_index) < MAX_DESTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sources <= CNT_W'(1);
      num_dests   <= CNT_W'(1);
      walk_row    <= '0;
      walk_col    <= '0;
      cost_total  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_SOURCES: num_sources <= cfg_data;
          REG_NUM_DESTS:   num_dests   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.balance) begin
        walk_row   <= '0;
        walk_col   <= '0;
        cost_total <= '0;
      end
      if (cmd.walk) begin
        // Move down when the supply ran out first, otherwise right.
        if (s_lt_d) begin
          walk_row <= walk_row + CNT_W'(1);
        end else begin
          walk_col <= walk_col + CNT_W'(1);
        end
      end
      if (cmd.acc) begin
        cost_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_word.action == ACT_SUPPLY && ld_row_ok) begin
      supply[CNT_W'(in_word.row_index)] <= AMT_W'(in_word.load_value);
    end
    if (cmd.load && in_word.action == ACT_DEMAND && ld_col_ok) begin
      demand[CNT_W'(in_word.col_index)] <= AMT_W'(in_word.load_value);
    end
    if (cmd.balance) begin
      if (sum_s < sum_d) begin
        supply[rm] <= AMT_W'(sum_d - sum_s);
      end else if (sum_d < sum_s) begin
        demand[rn] <= AMT_W'(sum_s - sum_d);
      end
    end
    if (cmd.walk) begin
      supply[walk_row] <= s_lt_d ? '0 : s_minus_d;
      demand[walk_col] <= s_lt_d ? d_minus_s : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_word.action == ACT_COST && ld_row_ok && ld_col_ok) begin
      cost_mem[{in_word.row_index, in_word.col_index}] <= in_word.load_value;
    end
    if (cmd.walk) begin
      cost_rd <= cost_mem[{walk_row[ROW_W-1:0], walk_col[COL_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      sidx  <= '0;
      sum_s <= '0;
      sum_d <= '0;
      rm    <= ns_clamp;
      rn    <= nd_clamp;
    end
    if (cmd.sum_step) begin
      sidx <= sidx + SIDX_W'(1);
      if (CNT_W'(sidx) < rm) begin
        sum_s <= sum_s + SUM_W'(sup_rd);
      end
      if (CNT_W'(sidx) < rn) begin
        sum_d <= sum_d + SUM_W'(dem_rd);
      end
    end
    if (cmd.balance) begin
      step_cnt <= '0;
      if (sum_s < sum_d) begin
        kind   <= BAL_DUMMY_SRC;
        remain <= sum_d;
        m_lim  <= rm + CNT_W'(1);
        n_lim  <= rn;
      end else if (sum_d < sum_s) begin
        kind   <= BAL_DUMMY_DST;
        remain <= sum_s;
        m_lim  <= rm;
        n_lim  <= rn + CNT_W'(1);
      end else begin
        kind   <= BAL_NONE;
        remain <= sum_s;
        m_lim  <= rm;
        n_lim  <= rn;
      end
    end
    if (cmd.walk) begin
      cur_row <= walk_row;
      cur_col <= walk_col;
      amt     <= s_lt_d ? sup_rd : dem_rd;
      // Cells of the dummy row or column cost nothing.
      dummy   <= !((walk_row < rm) && (walk_col < rn));
    end
    if (cmd.mul) begin
      prod   <= PROD_W'(amt) * PROD_W'(uc);
      remain <= remain - SUM_W'(amt);
    end
    if (cmd.acc) begin
      step_cnt             <= step_next;
      out_reg.alloc_row    <= cur_row;
      out_reg.alloc_col    <= cur_col;
      out_reg.alloc_amount <= amt;
      out_reg.running_cost <= total_next;
      out_reg.balance_kind <= kind;
      out_reg.last_step    <= last_now;
    end
  end

  assign stat.sum_done = (sidx == SIDX_W'(SUM_LEN - 1));
  assign stat.last     = out_reg.last_step;
  assign out_word      = out_reg;

endmodule

// ===== design/northwest_corner_transport_allocator.sv =====
// Channel | Direction | Handshake          | Word
// cfg     | in        | cfg_we             | cfg_index, cfg_data (num_sources, num_dests)
// in      | in        | in_valid/in_ready  | in_word: action, row_index, col_index, load_value
// out     | out       | out_valid/out_ready| out_word: cell, amount, running cost, kind, last
//
// A load word is taken without leaving the idle state, so the block stays ready.
// A run word first sums supplies and demands over the whole table, one entry of each per
// cycle, then balances the problem, then produces each result word in turn through the
// steps read tables, multiply, accumulate and present.
// The output register holds a result word while out_ready is low; the walk waits.
// No input word is accepted while a run is in progress.
// Reset is synchronous and active high; it sets both counts to one and clears the
// walk position and cost total. The supply, demand and cost tables are not cleared.
module northwest_corner_transport_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nwca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nwca_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nwca_pkg::nwca_in_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output nwca_pkg::nwca_out_t            out_word
);
  import nwca_pkg::*;

  nwca_cmd_t  cmd;
  nwca_stat_t stat;

  nwca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_word.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  nwca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import nwca_pkg::*;

  localparam int RANDOM_ITEMS  = 240;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int SCRIPT_LEN    = 23;

  typedef struct packed {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CNT_W-1:0]     reg_val;
    nwca_in_t             word;
    bit                   typed;
    nwca_out_t            answer;
  } script_row_t;

  localparam nwca_in_t  NO_WORD   = '0;
  localparam nwca_out_t NO_ANSWER = '0;
  localparam nwca_out_t IDLE_RUN  = '{5'd0, 5'd0, 20'd0, 41'd0, BAL_NONE, 1'b1};
  localparam nwca_out_t FULL_RUN  = '{5'd0, 5'd0, 20'd65535, 41'd4294836225, BAL_NONE, 1'b1};

  // Rows with a typed answer are runs whose single result is plain to see.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // All-zero problem: one word at the corner with nothing allotted.
    '{1'b0, '0, '0, '{ACT_SUPPLY, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_DEMAND, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_COST, 4'd0, 4'd0, 16'd65535}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_RUN, 4'd0, 4'd0, 16'd0}, 1'b1, IDLE_RUN},
    // Largest amount times largest unit cost.
    '{1'b0, '0, '0, '{ACT_SUPPLY, 4'd0, 4'd0, 16'd65535}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_DEMAND, 4'd0, 4'd0, 16'd65535}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_RUN, 4'd15, 4'd15, 16'd65535}, 1'b1, FULL_RUN},
    // Surplus supply adds a dummy destination, then a shortfall adds a dummy source.
    '{1'b0, '0, '0, '{ACT_SUPPLY, 4'd0, 4'd0, 16'd5}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_RUN, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_DEMAND, 4'd0, 4'd0, 16'd7}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_RUN, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER},
    // A tie moves right and the following cell gets a zero amount.
    '{1'b1, REG_NUM_SOURCES, 5'd2, NO_WORD, 1'b0, NO_ANSWER},
    '{1'b1, REG_NUM_DESTS, 5'd2, NO_WORD, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_SUPPLY, 4'd0, 4'd0, 16'd3}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_SUPPLY, 4'd1, 4'd0, 16'd2}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_DEMAND, 4'd0, 4'd0, 16'd3}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_DEMAND, 4'd0, 4'd1, 16'd2}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_COST, 4'd0, 4'd1, 16'd1}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_COST, 4'd1, 4'd1, 16'd65535}, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_RUN, 4'd0, 4'd0, 16'd0}, 1'b0, NO_ANSWER},
    // Zero counts act as one; a repeated run sees only the emptied entries.
    '{1'b1, REG_NUM_SOURCES, 5'd0, NO_WORD, 1'b0, NO_ANSWER},
    '{1'b1, REG_NUM_DESTS, 5'd0, NO_WORD, 1'b0, NO_ANSWER},
    '{1'b0, '0, '0, '{ACT_RUN, 4'd0, 4'd0, 16'd0}, 1'b1, IDLE_RUN}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  nwca_in_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  nwca_out_t            out_word;

  // Own copy of the allocator state, updated as words are accepted.
  logic [AMT_W-1:0] supply_mem [0:MAX_SOURCES];
  logic [AMT_W-1:0] demand_mem [0:MAX_DESTS];
  logic [VAL_W-1:0] cost_mem   [0:MAX_SOURCES-1][0:MAX_DESTS-1];
  bit               supply_set [0:MAX_SOURCES];
  bit               demand_set [0:MAX_DESTS];
  bit               cost_set   [0:MAX_SOURCES-1][0:MAX_DESTS-1];
  logic [CNT_W-1:0] sources_reg = 5'd1;
  logic [CNT_W-1:0] dests_reg   = 5'd1;

  nwca_out_t walk_steps [$];
  nwca_out_t due_allocs [$];
  nwca_out_t head_alloc;

  int send_idle_pct = 14;
  int recv_idle_pct = 88;
  int fault_count   = 0;
  int words_checked = 0;
  int item_count    = 0;
  int run_count     = 0;
  int kind_count [3];
  int quiet_cycles  = 0;

  northwest_corner_transport_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  function automatic int clamp_count(input logic [CNT_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // North-west corner walk over the current tables. Results land in walk_steps;
  // the tables are only updated when commit is set, so the walk can be planned.
  function automatic void nw_corner_walk(input bit commit);
    logic [AMT_W-1:0]  sup [0:MAX_SOURCES];
    logic [AMT_W-1:0]  dem [0:MAX_DESTS];
    longint unsigned   sum_s, sum_d, remain, gap;
    int                rm, rn, m, n, r, c, steps;
    logic [AMT_W-1:0]  s, d, amt;
    logic [VAL_W-1:0]  uc;
    logic [COST_W-1:0] total;
    logic [KIND_W-1:0] kind;
    nwca_out_t         cell_word;
    for (int i = 0; i <= MAX_SOURCES; i++) sup[i] = supply_mem[i];
    for (int i = 0; i <= MAX_DESTS; i++) dem[i] = demand_mem[i];
    rm = clamp_count(sources_reg, MAX_SOURCES);
    rn = clamp_count(dests_reg, MAX_DESTS);
    m = rm;
    n = rn;
    sum_s = 0;
    sum_d = 0;
    for (int i = 0; i < rm; i++) sum_s += sup[i];
    for (int i = 0; i < rn; i++) sum_d += dem[i];
    kind = BAL_NONE;
    remain = sum_s;
    if (sum_s < sum_d) begin
      gap = sum_d - sum_s;
      sup[rm] = gap[AMT_W-1:0];
      m = rm + 1;
      kind = BAL_DUMMY_SRC;
      remain = sum_d;
    end else if (sum_d < sum_s) begin
      gap = sum_s - sum_d;
      dem[rn] = gap[AMT_W-1:0];
      n = rn + 1;
      kind = BAL_DUMMY_DST;
    end
    walk_steps.delete();
    r = 0;
    c = 0;
    total = '0;
    steps = 0;
    do begin
      s = sup[r];
      d = dem[c];
      amt = (s < d) ? s : d;
      uc = (r < rm && c < rn) ? cost_mem[r][c] : '0;
      sup[r] = s - amt;
      dem[c] = d - amt;
      remain -= amt;
      total = total + amt * uc;
      cell_word.alloc_row    = CNT_W'(r);
      cell_word.alloc_col    = CNT_W'(c);
      cell_word.alloc_amount = amt;
      cell_word.running_cost = total;
      cell_word.balance_kind = kind;
      cell_word.last_step    = 1'b0;
      walk_steps.push_back(cell_word);
      if (s < d) r++;
      else c++;
      steps++;
    end while (remain != 0 && r < m && c < n && steps < MAX_STEPS);
    cell_word = walk_steps.pop_back();
    cell_word.last_step = 1'b1;
    walk_steps.push_back(cell_word);
    if (commit) begin
      for (int i = 0; i <= MAX_SOURCES; i++) supply_mem[i] = sup[i];
      for (int i = 0; i <= MAX_DESTS; i++) demand_mem[i] = dem[i];
      if (kind == BAL_DUMMY_SRC) supply_set[rm] = 1'b1;
      if (kind == BAL_DUMMY_DST) demand_set[rn] = 1'b1;
    end
  endfunction

  function automatic void match_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t  %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic nwca_in_t pack_word(input logic [1:0] act, input int r, input int c,
                                         input logic [VAL_W-1:0] v);
    nwca_in_t w;
    w.action     = act;
    w.row_index  = ROW_W'(r);
    w.col_index  = COL_W'(c);
    w.load_value = v;
    return w;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(3));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return VAL_W'($urandom_range(200));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return CNT_W'(16);
    if (roll < 10) return CNT_W'($urandom_range(31, 17));
    if (roll < 13) return '0;
    return CNT_W'($urandom_range(4, 1));
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input nwca_in_t w, input bit typed = 1'b0,
                           input nwca_out_t answer = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    item_count++;
    case (w.action)
      ACT_SUPPLY: begin
        supply_mem[w.row_index] = w.load_value;
        supply_set[w.row_index] = 1'b1;
      end
      ACT_DEMAND: begin
        demand_mem[w.col_index] = w.load_value;
        demand_set[w.col_index] = 1'b1;
      end
      ACT_COST: begin
        cost_mem[w.row_index][w.col_index] = w.load_value;
        cost_set[w.row_index][w.col_index] = 1'b1;
      end
      default: begin
        nw_corner_walk(1'b1);
        run_count++;
        kind_count[walk_steps[0].balance_kind]++;
        if (typed) due_allocs.push_back(answer);
        else foreach (walk_steps[k]) due_allocs.push_back(walk_steps[k]);
      end
    endcase
  endtask

  // Hold off new words until every result has been taken and the block is idle.
  task automatic drain_and_pause();
    in_valid <= 1'b0;
    while (due_allocs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_NUM_SOURCES) sources_reg = val;
    else dests_reg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One transportation problem: optional new counts, table loads, stray loads,
  // cost loads for the cells the walk will touch, then the run word.
  task automatic pose_problem(input bit force_big);
    int               rm, rn, rest, cap, n_noise;
    bit               fresh;
    logic [VAL_W-1:0] v;
    logic [1:0]       act;
    if (force_big || $urandom_range(9) < 3) begin
      drain_and_pause();
      if (force_big) begin
        write_reg(REG_NUM_SOURCES, 5'd31);
        write_reg(REG_NUM_DESTS, 5'd16);
      end else begin
        if ($urandom_range(1)) write_reg(REG_NUM_SOURCES, pick_count());
        if ($urandom_range(1)) write_reg(REG_NUM_DESTS, pick_count());
      end
    end
    rm = clamp_count(sources_reg, MAX_SOURCES);
    rn = clamp_count(dests_reg, MAX_DESTS);
    fresh = force_big || ($urandom_range(4) != 0);
    for (int i = 0; i < rm; i++)
      if (fresh || !supply_set[i]) send_word(pack_word(ACT_SUPPLY, i, 0, pick_value()));
    if (fresh && $urandom_range(9) < 4) begin
      // Split the total supply over the columns so the problem mostly balances.
      rest = 0;
      for (int i = 0; i < rm; i++) rest += int'(supply_mem[i]);
      for (int j = 0; j < rn; j++) begin
        cap = (rest > 65535) ? 65535 : rest;
        v = (j == rn - 1) ? VAL_W'(cap) : VAL_W'($urandom_range(cap, 0));
        rest -= int'(v);
        send_word(pack_word(ACT_DEMAND, 0, j, v));
      end
    end else begin
      for (int j = 0; j < rn; j++)
        if (fresh || !demand_set[j]) send_word(pack_word(ACT_DEMAND, 0, j, pick_value()));
    end
    n_noise = $urandom_range(2);
    for (int k = 0; k < n_noise; k++) begin
      case ($urandom_range(2))
        0: act = ACT_SUPPLY;
        1: act = ACT_DEMAND;
        default: act = ACT_COST;
      endcase
      send_word(pack_word(act, $urandom_range(15), $urandom_range(15), pick_value()));
    end
    nw_corner_walk(1'b0);
    foreach (walk_steps[k]) begin
      if (walk_steps[k].alloc_row < rm && walk_steps[k].alloc_col < rn &&
          (!cost_set[walk_steps[k].alloc_row][walk_steps[k].alloc_col] ||
           $urandom_range(2) == 0))
        send_word(pack_word(ACT_COST, walk_steps[k].alloc_row, walk_steps[k].alloc_col,
                            pick_value()));
    end
    send_word(pack_word(ACT_RUN, $urandom_range(15), $urandom_range(15), VAL_W'($urandom)));
    if ($urandom_range(7) == 0) drain_and_pause();
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_allocs.size() == 0) begin
        fault_count++;
        $display("%0t  unexpected allocation word: expected none, got %p", $time, out_word);
      end else begin
        head_alloc = due_allocs.pop_front();
        words_checked++;
        match_field("alloc_row", head_alloc.alloc_row, out_word.alloc_row);
        match_field("alloc_col", head_alloc.alloc_col, out_word.alloc_col);
        match_field("alloc_amount", head_alloc.alloc_amount, out_word.alloc_amount);
        match_field("running_cost", head_alloc.running_cost, out_word.running_cost);
        match_field("balance_kind", head_alloc.balance_kind, out_word.balance_kind);
        match_field("last_step", head_alloc.last_step, out_word.last_step);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t  no handshake for %0d cycles, %0d words outstanding", $time,
               quiet_cycles, due_allocs.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int base;
    int phase;
    int problem;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      if (SCRIPT[k].is_reg) begin
        drain_and_pause();
        write_reg(SCRIPT[k].reg_idx, SCRIPT[k].reg_val);
      end else begin
        send_word(SCRIPT[k].word, SCRIPT[k].typed, SCRIPT[k].answer);
      end
    end

    base = item_count;
    phase = 0;
    problem = 0;
    while (item_count < base + RANDOM_ITEMS) begin
      if (phase == 0 && item_count >= base + RANDOM_ITEMS / 3) begin
        send_idle_pct = 88;
        recv_idle_pct <= 14;
        phase = 1;
      end else if (phase == 1 && item_count >= base + 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        phase = 2;
      end
      pose_problem(problem == 0);
      problem++;
    end

    drain_and_pause();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input words in %0d runs: %0d balanced, %0d with a dummy source,",
             item_count, run_count, kind_count[BAL_NONE], kind_count[BAL_DUMMY_SRC]);
    $display("%0d with a dummy destination; %0d allocation words checked in three pacings.",
             kind_count[BAL_DUMMY_DST], words_checked);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
